### rtl/cn2s_pkg.sv
// cn2s_pkg: widths, constants and the square-root cell payload type for
// the carrier-to-noise to SNR converter. No dependencies.

package cn2s_pkg;

  // Field widths
  localparam int unsigned CnW  = 16;
  localparam int unsigned SnrW = 16;

  // Offset removed from the raw reading, wraps modulo 2^16
  localparam logic [CnW-1:0] CnOffset = 16'd3000;

  // Square root: one result bit per cell, two radicand bits consumed per cell
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned RootW     = 16;
  localparam int unsigned RemW      = 18;

  // Polynomial datapath
  localparam int unsigned XW     = 31;  // powers x1..x5 stay below 2^31
  localparam int unsigned AccW   = 32;  // wrapping accumulator
  localparam int unsigned X1Shft = 15;  // x1 = root * 32768

  // Fixed-point coefficients, all below 2^31
  localparam logic [XW-1:0] PolyC0 = XW'((64'd58857 << 23) / 64'd1000);
  localparam logic [XW-1:0] PolyC1 = XW'((64'd89565 << 24) / 64'd1000);
  localparam logic [XW-1:0] PolyC2 = XW'((64'd88977 << 24) / 64'd1000);
  localparam logic [XW-1:0] PolyC3 = XW'((64'd50259 << 25) / 64'd1000);
  localparam logic [XW-1:0] PolyC4 = XW'((64'd14341 << 27) / 64'd1000);
  localparam logic [XW-1:0] PolyC5 = XW'((64'd16346 << 30) / 64'd10000);

  // Payload handed from one square-root cell to the next
  typedef struct packed {
    logic [CnW-1:0]   rad;   // radicand bits not yet consumed, MSBs first
    logic [RemW-1:0]  rem;   // partial remainder
    logic [RootW-1:0] root;  // partial root
  } sqrt_t;

endpackage

### rtl/cn2s_if.sv
// cn2s_if: valid/ready channel interfaces for the reading input and the
// SNR result output. Depends on cn2s_pkg.

interface cn2s_in_if import cn2s_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [CnW-1:0] cn_raw;

  modport source (output valid, output cn_raw, input ready);
  modport sink   (input valid, input cn_raw, output ready);
endinterface

interface cn2s_out_if import cn2s_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SnrW-1:0] snr_value;

  modport source (output valid, output snr_value, input ready);
  modport sink   (input valid, input snr_value, output ready);
endinterface

### rtl/cn2s_sqrt_cell.sv
// cn2s_sqrt_cell: one registered step of the digit-by-digit square root,
// producing one root bit per cell. Depends on cn2s_pkg.

module cn2s_sqrt_cell import cn2s_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  sqrt_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output sqrt_t data_o
);

  logic              valid_q, valid_d;
  sqrt_t             data_q, data_d;
  logic [RemW+1:0]   rem_sh;
  logic [RemW+1:0]   trial;
  logic              take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    rem_sh = {data_i.rem, data_i.rad[CnW-1 -: 2]};
    trial  = (RemW+2)'({data_i.root, 2'b01});
    data_d.rad = {data_i.rad[CnW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      data_d.rem  = RemW'(rem_sh - trial);
      data_d.root = {data_i.root[RootW-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh[RemW-1:0];
      data_d.root = {data_i.root[RootW-2:0], 1'b0};
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef NO_ASSERTIONS
  // A stalled stage keeps its item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(data_q))
    else $error("sqrt cell lost or changed a stalled item");

  // Remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.rem <= RemW'({data_q.root, 1'b0})))
    else $error("sqrt cell remainder out of range");

  // A drained stage with nothing arriving goes empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ready_i && !valid_i |=> !valid_q)
    else $error("sqrt cell repeated an item");
`endif

endmodule

### rtl/cn2s_poly.sv
// cn2s_poly: five-stage pipeline that scales the root, builds the powers
// x2..x5, sums the degree-5 polynomial and clamps it. Depends on cn2s_pkg.

module cn2s_poly import cn2s_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [RootW-1:0] root_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [SnrW-1:0]  snr_value_o
);

  localparam int unsigned NumStg = 5;

  // (a * b) >> 31, both operands below 2^31
  function automatic logic [XW-1:0] pow_mul(input logic [XW-1:0] a,
                                            input logic [XW-1:0] b);
    logic [2*XW-1:0] p;
    p = (2*XW)'(a) * (2*XW)'(b);
    return p[2*XW-1:XW];
  endfunction

  // (a * b) >> sh, truncated to the accumulator width
  function automatic logic [AccW-1:0] term_mul(input logic [XW-1:0] a,
                                               input logic [XW-1:0] b,
                                               input int unsigned sh);
    logic [2*XW-1:0] p;
    p = (2*XW)'(a) * (2*XW)'(b);
    p = p >> sh;
    return p[AccW-1:0];
  endfunction

  logic [NumStg-1:0] v_q, v_d, v_in, load;
  logic [NumStg:0]   rdy;

  // Stage 1
  logic [XW-1:0]   x1_a_q, x2_a_q;
  logic [AccW-1:0] t1_q;
  logic [XW-1:0]   x1;
  // Stage 2
  logic [XW-1:0]   x1_b_q, x3_b_q, x4_b_q;
  logic [AccW-1:0] t2_q, acc2_q;
  // Stage 3
  logic [XW-1:0]   x5_q;
  logic [AccW-1:0] t3_q, t4_q, acc3_q;
  // Stage 4
  logic [AccW-1:0] t5_q, acc4_q;
  // Stage 5
  logic [AccW-1:0] acc5;
  logic [SnrW-1:0] snr_q, snr_d;

  assign rdy[NumStg] = ready_i;
  assign v_in[0]     = valid_i;

  for (genvar k = 0; k < NumStg; k++) begin : g_hs
    assign rdy[k]  = !v_q[k] || rdy[k+1];
    assign load[k] = v_in[k] && rdy[k];
    assign v_d[k]  = rdy[k] ? v_in[k] : v_q[k];
    if (k > 0) begin : g_vin
      assign v_in[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign x1 = {root_i, X1Shft'(0)};

  always_comb begin
    acc5  = acc4_q - t5_q;
    snr_d = acc5[AccW-1] ? '0 : acc5[X1Shft +: SnrW];
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      x1_a_q <= x1;
      x2_a_q <= pow_mul(x1, x1);
      t1_q   <= term_mul(x1, PolyC1, 30);
    end
    if (load[1]) begin
      x1_b_q <= x1_a_q;
      x3_b_q <= pow_mul(x2_a_q, x1_a_q);
      x4_b_q <= pow_mul(x2_a_q, x2_a_q);
      t2_q   <= term_mul(x2_a_q, PolyC2, 28);
      acc2_q <= AccW'(PolyC0) - t1_q;
    end
    if (load[2]) begin
      x5_q   <= pow_mul(x4_b_q, x1_b_q);
      t3_q   <= term_mul(x3_b_q, PolyC3, 27);
      t4_q   <= term_mul(x4_b_q, PolyC4, 27);
      acc3_q <= acc2_q + t2_q;
    end
    if (load[3]) begin
      t5_q   <= term_mul(x5_q, PolyC5, 28);
      acc4_q <= acc3_q - t3_q + t4_q;
    end
    if (load[4]) begin
      snr_q <= snr_d;
    end
  end

  assign ready_o     = rdy[0];
  assign valid_o     = v_q[NumStg-1];
  assign snr_value_o = snr_q;

`ifndef NO_ASSERTIONS
  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(snr_q))
    else $error("poly output changed while stalled");

  // Powers derived from x1 never exceed x1 (all are below one in Q31)
  a_pow_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (x4_b_q <= x1_b_q) && (x3_b_q <= x1_b_q))
    else $error("poly power out of range");

  // The input side is held off only when every stage is full
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> (&v_q) && !ready_i)
    else $error("poly stalled with an empty stage");
`endif

endmodule

### rtl/cn_to_snr_converter.sv
// Carrier-to-noise reading to fixed-point SNR figure: offset removal, a chain
// of 16 square-root cells and a 5-stage polynomial pipeline.
// Throughput: one reading per cycle; each stage advances on its own when the
// next one is free, so bubbles collapse and a stall only backs up when full.
// Reset (rst_ni, asynchronous, active low) clears the stage valid bits only.

module cn_to_snr_converter import cn2s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cn2s_in_if.sink    in_i,
  cn2s_out_if.source out_o
);

  // Handshake and payload between neighboring square-root cells.
  // Position 0 is the input port, position SqrtSteps feeds the polynomial.
  logic [SqrtSteps:0] c_valid;
  logic [SqrtSteps:0] c_ready;
  sqrt_t              c_data [SqrtSteps+1];
  logic [CnW-1:0]     cn_off;

  // Offset removal wraps modulo 2^16, so low readings give a large radicand.
  // The 16 zero bits appended below the reading are never stored: each cell
  // shifts zeros in behind the radicand as it consumes two bits.
  assign cn_off     = in_i.cn_raw - CnOffset;
  assign c_valid[0] = in_i.valid;
  assign in_i.ready = c_ready[0];
  assign c_data[0]  = '{rad: cn_off, rem: '0, root: '0};

  // One root bit per cell, most significant first.
  for (genvar g = 0; g < SqrtSteps; g++) begin : g_cell
    cn2s_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[g]),
      .ready_o (c_ready[g]),
      .data_i  (c_data[g]),
      .valid_o (c_valid[g+1]),
      .ready_i (c_ready[g+1]),
      .data_o  (c_data[g+1])
    );
  end

  // Powers, polynomial sum and clamp; its last stage is the output register.
  cn2s_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (c_valid[SqrtSteps]),
    .ready_o     (c_ready[SqrtSteps]),
    .root_i      (c_data[SqrtSteps].root),
    .valid_o     (out_o.valid),
    .ready_i     (out_o.ready),
    .snr_value_o (out_o.snr_value)
  );

`ifndef NO_ASSERTIONS
  // Input side is never held off while the first cell is empty
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !c_valid[1] |-> in_i.ready)
    else $error("input held off with an empty first cell");

  // A reading taken at the input reaches the first cell next cycle
  a_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> c_valid[1])
    else $error("accepted reading dropped at the first cell");

  // The final remainder never exceeds twice the final root
  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[SqrtSteps] |->
      (c_data[SqrtSteps].rem <= RemW'({c_data[SqrtSteps].root, 1'b0})))
    else $error("square root remainder out of range");
`endif

endmodule
